[sv/lsr_pkg.sv]
// Package with shared types and constants for the letter string range block.
`default_nettype none

package lsr_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned COUNT_W  = 16;

  localparam logic [POS_W-1:0] LENGTH_RESET = 16'h8000;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_COUNT  = 2'd1,
    CMD_ASSIGN = 2'd2,
    CMD_SORT   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic rd;
    logic inc;
    logic clr;
  } hist_cmd_t;

endpackage

`default_nettype wire

[sv/lsr_hist.sv]
// Histogram memory with read-increment-write and forwarding of the last write.
`default_nettype none

module lsr_hist #(
  parameter int unsigned ALPHABET_SIZE = 26,
  parameter int unsigned KW            = 5,
  parameter int unsigned CW            = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lsr_pkg::hist_cmd_t cmd_i,
  input  wire logic [KW-1:0]      addr_i,
  output logic      [CW-1:0]      rdata_o,
  output logic                    pend_o
);
  import lsr_pkg::*;

  logic [CW-1:0] mem [ALPHABET_SIZE];
  logic [CW-1:0] rdata_q;
  logic          hv_q;
  logic [KW-1:0] ha_q;
  logic          lw_v_q;
  logic [KW-1:0] lw_a_q;
  logic [CW-1:0] lw_d_q;
  logic [CW-1:0] inc_val;

  assign inc_val = ((lw_v_q && (lw_a_q == ha_q)) ? lw_d_q : rdata_q) + CW'(1);

  always_ff @(posedge clk_i) begin
    if (hv_q) begin
      mem[ha_q] <= inc_val;
    end else if (cmd_i.clr) begin
      mem[addr_i] <= '0;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr_i];
    end
    ha_q   <= addr_i;
    lw_a_q <= ha_q;
    lw_d_q <= inc_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q   <= 1'b0;
      lw_v_q <= 1'b0;
    end else begin
      hv_q   <= cmd_i.rd && cmd_i.inc;
      lw_v_q <= hv_q;
    end
  end

  assign rdata_o = rdata_q;
  assign pend_o  = hv_q;

endmodule

`default_nettype wire

[sv/letter_string_range_count_assign_sort.sv]
// Top level of the letter string with range count, range assign and range sort.
//
// A request is taken at a rising edge with start_i high and busy_o low. Each
// request gives one result: done_o is high for one cycle with letter_count_o
// and range_error_o; the receiver takes it in that cycle and cannot stall it.
// string_length_i is written at an edge with string_length_we_i high; the user
// must do so only while idle, which the block itself does not enforce.
// Work per request, N = range length, A = ALPHABET_SIZE:
//   write or any rejected request: result in the next cycle, busy_o stays low,
//     so such requests may follow each other in every cycle;
//   count: N store reads, one a cycle, then the last read drains;
//   assign: N store writes, one a cycle;
//   sort: the A histogram entries are cleared, N reads count letters, the
//     histogram update drains, then each letter costs a histogram read, a
//     load and a step to the next letter, plus one store write per position.
// The letter store is read and written in separate states. Reset clears the
// control state and sets string_length to 32768; the letter store holds
// nothing defined until the host loads every position.
`default_nettype none

module letter_string_range_count_assign_sort #(
  parameter int unsigned MAX_LENGTH    = 32768,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          string_length_we_i,
  input  wire logic [lsr_pkg::POS_W-1:0]     string_length_i,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [lsr_pkg::POS_W-1:0]     range_start_i,
  input  wire logic [lsr_pkg::POS_W-1:0]     range_end_i,
  input  wire logic [lsr_pkg::LETTER_W-1:0]  letter_i,
  output logic                               done_o,
  output logic [lsr_pkg::COUNT_W-1:0]        letter_count_o,
  output logic                               range_error_o
);
  import lsr_pkg::*;

  localparam int unsigned AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned CW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned KW = $clog2(ALPHABET_SIZE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASSIGN,
    S_CLEAR,
    S_SCAN,
    S_DRAIN,
    S_WREAD,
    S_WLOAD,
    S_WRITE
  } state_e;

  function automatic logic [AW-1:0] pos_addr(input logic [POS_W-1:0] p);
    logic [AW+POS_W-1:0] w;
    w = {{AW{1'b0}}, p - POS_W'(1)};
    return w[AW-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [POS_W-1:0]     len_q;
  logic [AW-1:0]        idx_q, idx_d;
  logic [AW-1:0]        beg_q, beg_d;
  logic [AW-1:0]        end_q, end_d;
  logic [LETTER_W-1:0]  letter_q, letter_d;
  logic                 sort_q, sort_d;
  logic [KW-1:0]        k_q, k_d;
  logic [CW-1:0]        n_q, n_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 rd_v_q;
  logic                 done_q, done_d;
  logic                 err_q, err_d;
  logic [COUNT_W-1:0]   lc_q, lc_d;

  logic [LETTER_W-1:0]  store [MAX_LENGTH];
  logic [LETTER_W-1:0]  st_rdata_q;
  logic                 st_we, st_re;
  logic [AW-1:0]        st_waddr;
  logic [LETTER_W-1:0]  st_wdata;

  hist_cmd_t            h_cmd;
  logic [KW-1:0]        h_addr;
  logic [CW-1:0]        h_rdata;
  logic                 h_pend;

  logic                 accept;
  logic                 bad_write, bad_range, bad_letter;
  logic [KW+LETTER_W-1:0] c_ext;
  logic [KW+LETTER_W-1:0] k_ext;
  logic [CW+COUNT_W-1:0]  cnt_ext;
  logic                 c_ok;

  assign accept     = start_i && (state_q == S_IDLE);
  assign bad_letter = 32'(letter_i) >= 32'(ALPHABET_SIZE);
  assign bad_write  = (range_start_i == '0) || (range_start_i > len_q) ||
                      (32'(range_start_i) > 32'(MAX_LENGTH)) || bad_letter;
  assign bad_range  = (range_start_i == '0) || (range_start_i > range_end_i) ||
                      (range_end_i > len_q) || (32'(range_end_i) > 32'(MAX_LENGTH));

  assign c_ext   = {{KW{1'b0}}, st_rdata_q};
  assign k_ext   = {{LETTER_W{1'b0}}, k_q};
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_q};
  assign c_ok    = 32'(st_rdata_q) < 32'(ALPHABET_SIZE);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    beg_d    = beg_q;
    end_d    = end_q;
    letter_d = letter_q;
    sort_d   = sort_q;
    k_d      = k_q;
    n_d      = n_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    err_d    = 1'b0;
    lc_d     = '0;
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_waddr = idx_q;
    st_wdata = letter_q;
    h_cmd    = '0;
    h_addr   = k_q;

    if (rd_v_q) begin
      if (sort_q) begin
        h_cmd.rd  = c_ok;
        h_cmd.inc = c_ok;
        h_addr    = c_ext[KW-1:0];
      end else if (st_rdata_q == letter_q) begin
        cnt_d = cnt_q + CW'(1);
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d    = pos_addr(range_start_i);
          beg_d    = pos_addr(range_start_i);
          end_d    = pos_addr(range_end_i);
          letter_d = letter_i;
          cnt_d    = '0;
          k_d      = '0;
          case (cmd_e'(cmd_i))
            CMD_WRITE: begin
              done_d = 1'b1;
              err_d  = bad_write;
              if (!bad_write) begin
                st_we    = 1'b1;
                st_waddr = pos_addr(range_start_i);
                st_wdata = letter_i;
              end
            end
            CMD_COUNT: begin
              if (bad_range) begin
                done_d = 1'b1;
                err_d  = 1'b1;
              end else begin
                sort_d  = 1'b0;
                state_d = S_SCAN;
              end
            end
            CMD_ASSIGN: begin
              if (bad_range || bad_letter) begin
                done_d = 1'b1;
                err_d  = 1'b1;
              end else begin
                state_d = S_ASSIGN;
              end
            end
            CMD_SORT: begin
              if (bad_range) begin
                done_d = 1'b1;
                err_d  = 1'b1;
              end else begin
                sort_d  = 1'b1;
                state_d = S_CLEAR;
              end
            end
            default: begin
              done_d = 1'b1;
              err_d  = 1'b1;
            end
          endcase
        end
      end
      S_ASSIGN: begin
        st_we = 1'b1;
        idx_d = idx_q + AW'(1);
        if (idx_q == end_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        h_cmd.clr = 1'b1;
        h_addr    = k_q;
        k_d       = k_q + KW'(1);
        if (k_q == KW'(ALPHABET_SIZE - 1)) begin
          k_d     = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        st_re = 1'b1;
        idx_d = idx_q + AW'(1);
        if (idx_q == end_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !h_pend) begin
          if (sort_q) begin
            idx_d   = beg_q;
            state_d = S_WREAD;
          end else begin
            done_d  = 1'b1;
            lc_d    = cnt_ext[COUNT_W-1:0];
            state_d = S_IDLE;
          end
        end
      end
      S_WREAD: begin
        h_cmd.rd = 1'b1;
        h_addr   = k_q;
        state_d  = S_WLOAD;
      end
      S_WLOAD: begin
        n_d     = h_rdata;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (n_q != '0) begin
          st_we    = 1'b1;
          st_wdata = k_ext[LETTER_W-1:0];
          idx_d    = idx_q + AW'(1);
          n_d      = n_q - CW'(1);
        end else if (k_q == KW'(ALPHABET_SIZE - 1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          k_d     = k_q + KW'(1);
          state_d = S_WREAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= LENGTH_RESET;
      rd_v_q  <= 1'b0;
      done_q  <= 1'b0;
      sort_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (string_length_we_i) begin
        len_q <= string_length_i;
      end
      rd_v_q  <= st_re;
      done_q  <= done_d;
      sort_q  <= sort_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    beg_q    <= beg_d;
    end_q    <= end_d;
    letter_q <= letter_d;
    k_q      <= k_d;
    n_q      <= n_d;
    cnt_q    <= cnt_d;
    err_q    <= err_d;
    lc_q     <= lc_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= store[idx_q];
    end
  end

  lsr_hist #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .KW           (KW),
    .CW           (CW)
  ) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (h_cmd),
    .addr_i (h_addr),
    .rdata_o(h_rdata),
    .pend_o (h_pend)
  );

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign letter_count_o = lc_q;
  assign range_error_o  = err_q;

endmodule

`default_nettype wire

[sv/lsr_checker.sv]
// Port-level checker for the letter string range block, with its bind.
`default_nettype none

module lsr_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start_i,
  input wire logic                          busy_o,
  input wire logic [1:0]                    cmd_i,
  input wire logic [lsr_pkg::POS_W-1:0]     range_start_i,
  input wire logic [lsr_pkg::POS_W-1:0]     range_end_i,
  input wire logic                          done_o,
  input wire logic [lsr_pkg::COUNT_W-1:0]   letter_count_o,
  input wire logic                          range_error_o
);
  import lsr_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == CMD_WRITE)) |=> (done_o && !busy_o))
    else $error("write request did not finish in one cycle");

  a_bad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i != CMD_WRITE) && (range_start_i > range_end_i))
      |=> (done_o && range_error_o))
    else $error("empty range not rejected at once");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && range_error_o) |-> (letter_count_o == '0))
    else $error("rejected request carries a count");

  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a request");

endmodule

bind letter_string_range_count_assign_sort lsr_checker u_lsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .cmd_i         (cmd_i),
  .range_start_i (range_start_i),
  .range_end_i   (range_end_i),
  .done_o        (done_o),
  .letter_count_o(letter_count_o),
  .range_error_o (range_error_o)
);

`default_nettype wire

[dv/tb_top.sv]
// Testbench for the letter string block: a directed table, then random requests checked by a predictor.
`timescale 1ns / 100ps

module tb_top;
  import lsr_pkg::*;

  localparam int unsigned MAX_LEN     = 32768;
  localparam int unsigned ALPHA       = 26;
  localparam int unsigned CYCLE_LIMIT = 25_000_000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS = 13;

  typedef struct packed {
    cmd_e             cmd;
    logic [POS_W-1:0] range_lo;
    logic [POS_W-1:0] range_hi;
    logic [LETTER_W-1:0] letter;
    logic             typed;
    logic [COUNT_W-1:0] exp_count;
    logic             exp_err;
  } stim_row_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               err;
  } count_result_t;

  localparam stim_row_t DIRECTED [25] = '{
    '{CMD_WRITE,  16'd0,     16'd0,     5'd3,  1'b1, 16'd0,     1'b1},
    '{CMD_WRITE,  16'd32769, 16'd0,     5'd3,  1'b1, 16'd0,     1'b1},
    '{CMD_WRITE,  16'd1,     16'd0,     5'd26, 1'b1, 16'd0,     1'b1},
    '{CMD_WRITE,  16'd1,     16'd1,     5'd31, 1'b1, 16'd0,     1'b1},
    '{CMD_COUNT,  16'd0,     16'd5,     5'd0,  1'b1, 16'd0,     1'b1},
    '{CMD_ASSIGN, 16'd10,    16'd9,     5'd1,  1'b1, 16'd0,     1'b1},
    '{CMD_SORT,   16'd1,     16'd65535, 5'd0,  1'b1, 16'd0,     1'b1},
    '{CMD_ASSIGN, 16'd1,     16'd32768, 5'd0,  1'b1, 16'd0,     1'b0},
    '{CMD_ASSIGN, 16'd1,     16'd5,     5'd26, 1'b1, 16'd0,     1'b1},
    '{CMD_COUNT,  16'd1,     16'd32768, 5'd0,  1'b1, 16'd32768, 1'b0},
    '{CMD_COUNT,  16'd1,     16'd32768, 5'd31, 1'b1, 16'd0,     1'b0},
    '{CMD_WRITE,  16'd1,     16'd0,     5'd25, 1'b1, 16'd0,     1'b0},
    '{CMD_WRITE,  16'd32768, 16'd65535, 5'd25, 1'b1, 16'd0,     1'b0},
    '{CMD_COUNT,  16'd1,     16'd32768, 5'd25, 1'b1, 16'd2,     1'b0},
    '{CMD_ASSIGN, 16'd100,   16'd163,   5'd7,  1'b0, 16'd0,     1'b0},
    '{CMD_WRITE,  16'd120,   16'd0,     5'd0,  1'b0, 16'd0,     1'b0},
    '{CMD_SORT,   16'd1,     16'd32768, 5'd9,  1'b0, 16'd0,     1'b0},
    '{CMD_COUNT,  16'd32767, 16'd32768, 5'd25, 1'b0, 16'd0,     1'b0},
    '{CMD_COUNT,  16'd1,     16'd1,     5'd0,  1'b0, 16'd0,     1'b0},
    '{CMD_SORT,   16'd5,     16'd5,     5'd0,  1'b0, 16'd0,     1'b0},
    '{CMD_SORT,   16'd3,     16'd2,     5'd0,  1'b1, 16'd0,     1'b1},
    '{CMD_COUNT,  16'd16,    16'd16,    5'd24, 1'b0, 16'd0,     1'b0},
    '{CMD_ASSIGN, 16'd32768, 16'd32768, 5'd13, 1'b0, 16'd0,     1'b0},
    '{CMD_COUNT,  16'd1,     16'd32768, 5'd13, 1'b0, 16'd0,     1'b0},
    '{CMD_SORT,   16'd90,    16'd200,   5'd0,  1'b0, 16'd0,     1'b0}
  };

  localparam logic [POS_W-1:0] PHASE_LEN [NUM_PHASES] =
    '{16'd1, 16'd0, 16'd65535, 16'd200, 16'd32768, 16'd7};
  localparam int unsigned PHASE_IDLE [NUM_PHASES] = '{0, 77, 29, 0, 77, 29};

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                string_length_we_i = 1'b0;
  logic [POS_W-1:0]    string_length_i    = '0;
  logic                start_i            = 1'b0;
  logic                busy_o;
  logic [1:0]          cmd_i              = '0;
  logic [POS_W-1:0]    range_start_i      = '0;
  logic [POS_W-1:0]    range_end_i        = '0;
  logic [LETTER_W-1:0] letter_i           = '0;
  logic                done_o;
  logic [COUNT_W-1:0]  letter_count_o;
  logic                range_error_o;

  logic [LETTER_W-1:0] letter_mirror [MAX_LEN];
  logic [POS_W-1:0]    length_mirror = LENGTH_RESET;
  count_result_t       pending_counts [$];
  count_result_t       oldest_count;
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;
  int unsigned         sender_idle_pct = 0;

  letter_string_range_count_assign_sort DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .string_length_we_i (string_length_we_i),
    .string_length_i    (string_length_i),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .cmd_i              (cmd_i),
    .range_start_i      (range_start_i),
    .range_end_i        (range_end_i),
    .letter_i           (letter_i),
    .done_o             (done_o),
    .letter_count_o     (letter_count_o),
    .range_error_o      (range_error_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic void predict_letter_op(input cmd_e c, input logic [POS_W-1:0] lo,
                                            input logic [POS_W-1:0] hi,
                                            input logic [LETTER_W-1:0] ltr,
                                            output count_result_t res);
    int unsigned eff;
    int unsigned n;
    int unsigned pos;
    int unsigned hist [ALPHA];
    res.count = '0;
    res.err   = 1'b0;
    eff = (length_mirror > MAX_LEN) ? MAX_LEN : length_mirror;
    n = 0;
    if (c == CMD_WRITE) begin
      if (lo == 0 || lo > eff || ltr >= ALPHA) res.err = 1'b1;
      else letter_mirror[lo-1] = ltr;
    end else if (lo == 0 || lo > hi || hi > eff) begin
      res.err = 1'b1;
    end else if (c == CMD_COUNT) begin
      for (int unsigned i = lo - 1; i < hi; i++)
        if (letter_mirror[i] == ltr) n++;
      res.count = n[COUNT_W-1:0];
    end else if (c == CMD_ASSIGN) begin
      if (ltr >= ALPHA) res.err = 1'b1;
      else for (int unsigned i = lo - 1; i < hi; i++) letter_mirror[i] = ltr;
    end else begin
      foreach (hist[k]) hist[k] = 0;
      for (int unsigned i = lo - 1; i < hi; i++)
        if (letter_mirror[i] < ALPHA) hist[letter_mirror[i]]++;
      pos = lo - 1;
      for (int unsigned k = 0; k < ALPHA; k++)
        for (int unsigned j = 0; j < hist[k] && pos < hi; j++) begin
          letter_mirror[pos] = k[LETTER_W-1:0];
          pos++;
        end
    end
  endfunction

  // hold each request until busy_o is low at an edge
  task automatic send_request(input cmd_e c, input logic [POS_W-1:0] lo,
                              input logic [POS_W-1:0] hi, input logic [LETTER_W-1:0] ltr,
                              input logic typed, input logic [COUNT_W-1:0] typed_count,
                              input logic typed_err);
    count_result_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    cmd_i         <= c;
    range_start_i <= lo;
    range_end_i   <= hi;
    letter_i      <= ltr;
    do @(posedge clk_i); while (busy_o);
    predict_letter_op(c, lo, hi, ltr, res);
    if (typed) begin
      res.count = typed_count;
      res.err   = typed_err;
    end
    pending_counts.push_back(res);
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_counts.size() != 0 || busy_o);
  endtask

  task automatic write_length(input logic [POS_W-1:0] value);
    string_length_we_i <= 1'b1;
    string_length_i    <= value;
    @(posedge clk_i);
    length_mirror = value;
    string_length_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_counts.size() == 0) begin
        report_mismatch("result with no request pending", 32'(letter_count_o), 0);
      end else begin
        oldest_count = pending_counts.pop_front();
        if (letter_count_o !== oldest_count.count)
          report_mismatch("letter_count", 32'(letter_count_o), 32'(oldest_count.count));
        if (range_error_o !== oldest_count.err)
          report_mismatch("range_error", 32'(range_error_o), 32'(oldest_count.err));
      end
    end
  end

  initial begin
    int unsigned eff;
    int unsigned span;
    int unsigned max_span;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic [LETTER_W-1:0] ltr;
    cmd_e c;

    foreach (letter_mirror[i]) letter_mirror[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[r])
      send_request(DIRECTED[r].cmd, DIRECTED[r].range_lo, DIRECTED[r].range_hi,
                   DIRECTED[r].letter, DIRECTED[r].typed, DIRECTED[r].exp_count,
                   DIRECTED[r].exp_err);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_results();
      write_length(PHASE_LEN[p]);
      sender_idle_pct = PHASE_IDLE[p];
      eff = (length_mirror > MAX_LEN) ? MAX_LEN : length_mirror;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        c = cmd_e'($urandom_range(3));
        if (eff != 0 && $urandom_range(99) < 80) begin
          max_span = ($urandom_range(39) == 0) ? eff - 1 : ((eff - 1 < 63) ? eff - 1 : 63);
          span = $urandom_range(max_span);
          lo   = POS_W'($urandom_range(eff - span, 1));
          hi   = POS_W'(32'(lo) + span);
          ltr  = LETTER_W'($urandom_range(ALPHA - 1));
        end else begin
          lo  = POS_W'($urandom_range(16'hFFFF));
          hi  = POS_W'($urandom_range(16'hFFFF));
          ltr = LETTER_W'($urandom_range(31));
        end
        send_request(c, lo, hi, ltr, 1'b0, '0, 1'b0);
        if ($urandom_range(15) == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_counts.size() != 0)
      report_mismatch("results missing", pending_counts.size(), 0);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/lsr_pkg.sv
sv/lsr_hist.sv
sv/letter_string_range_count_assign_sort.sv
sv/lsr_checker.sv
dv/tb_top.sv
